>>> hdl/hsvrgb_pkg.sv
`default_nettype none
package hsvrgb_pkg;

    localparam int CHANNELS = 3;
    localparam int STAGES   = 7;

    localparam logic [9:0]  HUE_PER_SECTOR = 10'd960;
    localparam logic [3:0]  MAX_QUOT       = 4'd8;
    localparam logic [3:0]  SECTORS        = 4'd6;
    localparam logic [6:0]  PCT_FULL       = 7'd100;
    localparam logic [16:0] FULL_TERM      = 17'd96000;

    // floor(N * 255 / 9600000) = floor(((N * 255) >> 9) / 18750)
    localparam logic [14:0] DIV_SHIFTED = 15'd18750;
    localparam logic [23:0] RECIP       = 24'd14660155;   // floor(2^38 / 18750)
    localparam int          RECIP_SHIFT = 38;

    localparam logic [2:0] SEC0 = 3'd0;
    localparam logic [2:0] SEC1 = 3'd1;
    localparam logic [2:0] SEC2 = 3'd2;
    localparam logic [2:0] SEC3 = 3'd3;
    localparam logic [2:0] SEC4 = 3'd4;
    localparam logic [2:0] SEC5 = 3'd5;

    typedef logic [16:0] term_t;
    typedef logic [23:0] num_t;
    typedef logic [22:0] quot_in_t;

endpackage
`default_nettype wire

>>> hdl/hsv_to_rgb_converter_unit.sv
`default_nettype none
// Throughput: one word per cycle while m_tready is high; each of the 7 stages advances when the
// stage after it is empty or moving, so a stall fills empty stages first.
// Reset (rst_n low, async): clears the stage valid bits; data regs keep state.
// The reciprocal multiply and its correction set the stage count.
module hsv_to_rgb_converter_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // hue[12:0], saturation[19:13], brightness[26:20]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0] m_tdata         // red[7:0], green[15:8], blue[23:16]
);

    localparam int NCH = hsvrgb_pkg::CHANNELS;
    localparam int NST = hsvrgb_pkg::STAGES;

    logic [NST:1] valid_reg;
    logic [NST:1] valid_next;
    logic [NST+1:1] en;

    // stage 1 comb
    logic [12:0] hue_in;
    logic [6:0]  sat_in;
    logic [6:0]  val_in;
    logic [3:0]  quot;
    logic [12:0] hue_base;
    logic [2:0]  sector_next;
    logic [9:0]  rem_next;

    logic [2:0]  sector_reg;
    logic [9:0]  rem_reg;
    logic [6:0]  sat1_reg;
    logic [6:0]  val1_reg;

    // stage 2
    hsvrgb_pkg::term_t wv, wp, wq, wt;
    hsvrgb_pkg::term_t w_next [NCH];
    hsvrgb_pkg::term_t w_reg  [NCH];
    logic [6:0] val2_reg;

    // stage 3..7
    hsvrgb_pkg::num_t     n_next [NCH];
    hsvrgb_pkg::num_t     n_reg  [NCH];
    logic [31:0]          p255   [NCH];
    hsvrgb_pkg::quot_in_t m_next [NCH];
    hsvrgb_pkg::quot_in_t m_reg  [NCH];
    logic [46:0]          prod   [NCH];
    logic [7:0]           q0_next [NCH];
    logic [7:0]           q0_reg  [NCH];
    hsvrgb_pkg::quot_in_t m5_reg  [NCH];
    hsvrgb_pkg::quot_in_t back    [NCH];
    hsvrgb_pkg::quot_in_t diff_next [NCH];
    hsvrgb_pkg::quot_in_t diff_reg  [NCH];
    logic [7:0]           q6_reg    [NCH];
    logic [7:0]           ch_next   [NCH];
    logic [7:0]           ch_reg    [NCH];

    // handshake / stage enables
    always_comb
    begin
        en[NST+1] = m_tready;
        for (int k = NST; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        for (int k = 1; k <= NST; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = (k == 1) ? s_tvalid : valid_reg[k-1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = valid_reg[NST];
    assign m_tdata  = {8'd0, ch_reg[2], ch_reg[1], ch_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stage 1: clamp, sector and remainder
    always_comb
    begin
        hue_in = s_tdata[12:0];
        sat_in = (s_tdata[19:13] > hsvrgb_pkg::PCT_FULL) ? hsvrgb_pkg::PCT_FULL
                                                        : s_tdata[19:13];
        val_in = (s_tdata[26:20] > hsvrgb_pkg::PCT_FULL) ? hsvrgb_pkg::PCT_FULL
                                                        : s_tdata[26:20];
        quot = 4'd0;
        for (int k = 1; k <= int'(hsvrgb_pkg::MAX_QUOT); k++)
        begin
            if (hue_in >= 13'(k * int'(hsvrgb_pkg::HUE_PER_SECTOR)))
            begin
                quot = quot + 4'd1;
            end
        end
        hue_base = 13'(13'(quot) * 13'(hsvrgb_pkg::HUE_PER_SECTOR));
        rem_next = 10'(hue_in - hue_base);
        sector_next = (quot >= hsvrgb_pkg::SECTORS) ? 3'(quot - hsvrgb_pkg::SECTORS)
                                                    : 3'(quot);
    end

    // stage 2: terms and channel select
    always_comb
    begin
        wv = hsvrgb_pkg::FULL_TERM;
        wp = 17'(17'(hsvrgb_pkg::PCT_FULL - sat1_reg) * 17'(hsvrgb_pkg::HUE_PER_SECTOR));
        wq = hsvrgb_pkg::FULL_TERM - 17'(17'(rem_reg) * 17'(sat1_reg));
        wt = hsvrgb_pkg::FULL_TERM
             - 17'(17'(hsvrgb_pkg::HUE_PER_SECTOR - rem_reg) * 17'(sat1_reg));
        case (sector_reg)
            hsvrgb_pkg::SEC0:
            begin
                w_next[0] = wv; w_next[1] = wt; w_next[2] = wp;
            end
            hsvrgb_pkg::SEC1:
            begin
                w_next[0] = wq; w_next[1] = wv; w_next[2] = wp;
            end
            hsvrgb_pkg::SEC2:
            begin
                w_next[0] = wp; w_next[1] = wv; w_next[2] = wt;
            end
            hsvrgb_pkg::SEC3:
            begin
                w_next[0] = wp; w_next[1] = wq; w_next[2] = wv;
            end
            hsvrgb_pkg::SEC4:
            begin
                w_next[0] = wt; w_next[1] = wp; w_next[2] = wv;
            end
            default:
            begin
                w_next[0] = wv; w_next[1] = wp; w_next[2] = wq;
            end
        endcase
    end

    // stages 3..7 per channel
    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            n_next[i]    = 24'(24'(val2_reg) * 24'(w_reg[i]));
            p255[i]      = (32'(n_reg[i]) << 8) - 32'(n_reg[i]);
            m_next[i]    = p255[i][31:9];
            prod[i]      = 47'(m_reg[i]) * 47'(hsvrgb_pkg::RECIP);
            q0_next[i]   = prod[i][hsvrgb_pkg::RECIP_SHIFT +: 8];
            back[i]      = 23'(23'(q0_reg[i]) * 23'(hsvrgb_pkg::DIV_SHIFTED));
            diff_next[i] = m5_reg[i] - back[i];
            ch_next[i]   = (diff_reg[i] >= 23'(hsvrgb_pkg::DIV_SHIFTED)) ? q6_reg[i] + 8'd1
                                                                      : q6_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sector_reg <= sector_next;
            rem_reg    <= rem_next;
            sat1_reg   <= sat_in;
            val1_reg   <= val_in;
        end
        if (en[2])
        begin
            w_reg    <= w_next;
            val2_reg <= val1_reg;
        end
        if (en[3])
        begin
            n_reg <= n_next;
        end
        if (en[4])
        begin
            m_reg <= m_next;
        end
        if (en[5])
        begin
            q0_reg <= q0_next;
            m5_reg <= m_reg;
        end
        if (en[6])
        begin
            diff_reg <= diff_next;
            q6_reg   <= q0_reg;
        end
        if (en[7])
        begin
            ch_reg <= ch_next;
        end
    end

`ifndef SYNTHESIS
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] |-> sector_reg <= hsvrgb_pkg::SEC5)
        else $error("sector out of range");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] |-> rem_reg < hsvrgb_pkg::HUE_PER_SECTOR)
        else $error("hue remainder out of range");

    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&valid_reg))
        else $error("input stalled with an empty stage");

    a_corr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[6] |-> (diff_reg[0] < 23'd37500) && (diff_reg[1] < 23'd37500)
                         && (diff_reg[2] < 23'd37500))
        else $error("reciprocal estimate off by more than one");
`endif

endmodule
`default_nettype wire

>>> bench/tb_hsv_to_rgb_converter_unit.sv
`default_nettype none
module tb_hsv_to_rgb_converter_unit;

    localparam int NUM_DIRECTED  = 24;
    localparam int NUM_RANDOM    = 850;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed
    {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed
    {
        logic [12:0] hue;
        logic [6:0]  sat;
        logic [6:0]  bri;
        logic        known;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } hsv_case_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_e;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;

    rgb_t     pending_rgb [$];
    int       fail_count  = 0;
    int       cycle_count = 0;
    int       burst_left  = 0;
    rx_mode_e rx_mode     = RX_OPEN;
    int       rx_left     = 0;

    // directed rows, some with known results: extremes, pure sector corners, clamping and wrap
    hsv_case_t directed_cases [NUM_DIRECTED] = '{
        '{13'd0,    7'd0,   7'd100, 1'b1, 8'd255, 8'd255, 8'd255},
        '{13'd0,    7'd0,   7'd0,   1'b1, 8'd0,   8'd0,   8'd0  },
        '{13'd0,    7'd100, 7'd100, 1'b1, 8'd255, 8'd0,   8'd0  },
        '{13'd960,  7'd100, 7'd100, 1'b1, 8'd255, 8'd255, 8'd0  },
        '{13'd1920, 7'd100, 7'd100, 1'b1, 8'd0,   8'd255, 8'd0  },
        '{13'd2880, 7'd100, 7'd100, 1'b1, 8'd0,   8'd255, 8'd255},
        '{13'd3840, 7'd100, 7'd100, 1'b1, 8'd0,   8'd0,   8'd255},
        '{13'd4800, 7'd100, 7'd100, 1'b1, 8'd255, 8'd0,   8'd255},
        '{13'd5760, 7'd100, 7'd100, 1'b1, 8'd255, 8'd0,   8'd0  },
        '{13'd0,    7'd127, 7'd127, 1'b1, 8'd255, 8'd0,   8'd0  },
        '{13'd8191, 7'd0,   7'd0,   1'b1, 8'd0,   8'd0,   8'd0  },
        '{13'd8191, 7'd127, 7'd127, 1'b0, 8'd0,   8'd0,   8'd0  },
        '{13'd5759, 7'd100, 7'd100, 1'b0, 8'd0,   8'd0,   8'd0  },
        '{13'd6720, 7'd50,  7'd100, 1'b0, 8'd0,   8'd0,   8'd0  },
        '{13'd7680, 7'd50,  7'd100, 1'b0, 8'd0,   8'd0,   8'd0  },
        '{13'd480,  7'd50,  7'd50,  1'b0, 8'd0,   8'd0,   8'd0  },
        '{13'd1440, 7'd73,  7'd91,  1'b0, 8'd0,   8'd0,   8'd0  },
        '{13'd2400, 7'd1,   7'd1,   1'b0, 8'd0,   8'd0,   8'd0  },
        '{13'd3360, 7'd99,  7'd100, 1'b0, 8'd0,   8'd0,   8'd0  },
        '{13'd4320, 7'd100, 7'd99,  1'b0, 8'd0,   8'd0,   8'd0  },
        '{13'd5280, 7'd64,  7'd64,  1'b0, 8'd0,   8'd0,   8'd0  },
        '{13'd959,  7'd100, 7'd100, 1'b0, 8'd0,   8'd0,   8'd0  },
        '{13'd961,  7'd100, 7'd100, 1'b0, 8'd0,   8'd0,   8'd0  },
        '{13'd4095, 7'd31,  7'd63,  1'b0, 8'd0,   8'd0,   8'd0  }
    };

    hsv_to_rgb_converter_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] channel_of(input longint unsigned num);
        return 8'((num * 255) / 9600000);
    endfunction

    function automatic rgb_t hsv_to_rgb_expected(input logic [12:0] hue,
                                                 input logic [6:0]  sat_in,
                                                 input logic [6:0]  bri_in);
        longint unsigned sat;
        longint unsigned bri;
        longint unsigned rem;
        longint unsigned v_term;
        longint unsigned p_term;
        longint unsigned q_term;
        longint unsigned t_term;
        logic [2:0]      sector;
        rgb_t            rgb;
        sat    = (sat_in > 7'd100) ? 100 : sat_in;
        bri    = (bri_in > 7'd100) ? 100 : bri_in;
        sector = 3'((hue / 960) % 6);
        rem    = hue % 960;
        v_term = bri * 96000;
        p_term = bri * (100 - sat) * 960;
        q_term = bri * (96000 - rem * sat);
        t_term = bri * (96000 - (960 - rem) * sat);
        case (sector)
            hsvrgb_pkg::SEC0:
                rgb = '{channel_of(v_term), channel_of(t_term), channel_of(p_term)};
            hsvrgb_pkg::SEC1:
                rgb = '{channel_of(q_term), channel_of(v_term), channel_of(p_term)};
            hsvrgb_pkg::SEC2:
                rgb = '{channel_of(p_term), channel_of(v_term), channel_of(t_term)};
            hsvrgb_pkg::SEC3:
                rgb = '{channel_of(p_term), channel_of(q_term), channel_of(v_term)};
            hsvrgb_pkg::SEC4:
                rgb = '{channel_of(t_term), channel_of(p_term), channel_of(v_term)};
            default:
                rgb = '{channel_of(v_term), channel_of(p_term), channel_of(q_term)};
        endcase
        return rgb;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        fail_count++;
    endtask

    // called at a rising edge; returns at the edge that accepted the word, or after an idle gap once the burst runs out
    task automatic send_word(input logic [12:0] hue, input logic [6:0] sat,
                             input logic [6:0] bri, input rgb_t want);
        s_tdata  <= {5'b0, bri, sat, hue};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_rgb.push_back(want);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    initial
    begin : stimulus
        hsv_case_t   row;
        rgb_t        want;
        logic [12:0] hue;
        logic [6:0]  sat;
        logic [6:0]  bri;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        burst_left = $urandom_range(0, 20);
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            row  = directed_cases[i];
            want = row.known ? rgb_t'({row.red, row.green, row.blue})
                             : hsv_to_rgb_expected(row.hue, row.sat, row.bri);
            send_word(row.hue, row.sat, row.bri, want);
        end
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            case ($urandom_range(0, 9))
                0:       hue = 13'($urandom_range(5760, 8191));
                1:       hue = 13'($urandom_range(0, 5) * 960 + ($urandom_range(0, 1) ? 959 : 0));
                default: hue = 13'($urandom_range(0, 5759));
            endcase
            case ($urandom_range(0, 9))
                0:       sat = 7'($urandom_range(101, 127));
                1:       sat = $urandom_range(0, 1) ? 7'd100 : 7'd0;
                default: sat = 7'($urandom_range(0, 100));
            endcase
            case ($urandom_range(0, 9))
                0:       bri = 7'($urandom_range(101, 127));
                1:       bri = $urandom_range(0, 1) ? 7'd100 : 7'd0;
                default: bri = 7'($urandom_range(0, 100));
            endcase
            send_word(hue, sat, bri, hsv_to_rgb_expected(hue, sat, bri));
        end
        s_tvalid <= 1'b0;
        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 60);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= (rx_left <= 1);
        endcase
    end

    always @(posedge clk)
    begin : result_check
        rgb_t got;
        rgb_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            // red sits in the low byte of the word
            got = rgb_t'({m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]});
            if (m_tdata[31:24] != 8'd0)
                report_mismatch("padding bits", m_tdata[31:24], 0);
            if (pending_rgb.size() == 0)
                report_mismatch("word with nothing pending", m_tdata, 0);
            else
            begin
                want = pending_rgb.pop_front();
                if (got.red != want.red)
                    report_mismatch("red", got.red, want.red);
                if (got.green != want.green)
                    report_mismatch("green", got.green, want.green);
                if (got.blue != want.blue)
                    report_mismatch("blue", got.blue, want.blue);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TIMEOUT with %0d words pending", pending_rgb.size());
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
`default_nettype wire
